// ===== rtl/rgb_fade_and_ramp_controller_core_assert.svh =====
// ----------------------------------------------------------------------------
// RGB fade and ramp controller assertion macros
// Shared assertion forms for the controller checker.
// ----------------------------------------------------------------------------
`ifndef RGB_FADE_AND_RAMP_CONTROLLER_CORE_ASSERT_SVH
`define RGB_FADE_AND_RAMP_CONTROLLER_CORE_ASSERT_SVH

// clocked check, aborted while reset is high
`define RFRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define RFRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB fade and ramp controller package
// Opcodes, register indexes, mode codes, lane control and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrc_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ON   = 2'd1;
  localparam logic [1:0] OP_OFF  = 2'd2;
  localparam logic [1:0] OP_FADE = 2'd3;

  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_INTERVAL   = 1'b1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;
  localparam logic [1:0] MODE_FADE = 2'd3;

  // floor(x / 100) == (x * 5243) >> 19 for x below 32768
  localparam logic [19:0] SCALE_RECIP = 20'd5243;
  localparam logic [19:0] FULL_FACTOR = 20'd524300;
  localparam logic [27:0] SCALE_BIAS  = 28'd262150;
  localparam int unsigned SCALE_SHIFT = 19;

  localparam logic [6:0] BRIGHT_RESET   = 7'd100;
  localparam logic [9:0] INTERVAL_RESET = 10'd3;

  typedef enum logic [3:0] {
    LN_HOLD       = 4'd0,
    LN_RAMP_START = 4'd1,
    LN_RAMP       = 4'd2,
    LN_BLANK      = 4'd3,
    LN_FADE_START = 4'd4,
    LN_FADE_STEP  = 4'd5,
    LN_FADE_END   = 4'd6,
    LN_REFRESH    = 4'd7
  } lane_op_t;

  typedef struct packed {
    lane_op_t    op;
    logic [19:0] factor;
    logic [7:0]  pct;
    logic [19:0] bright_factor;
  } lane_ctrl_t;

  typedef struct packed {
    logic [7:0] duty_red;
    logic [7:0] duty_green;
    logic [7:0] duty_blue;
    logic       power_on;
    logic [1:0] mode;
  } result_t;

  function automatic logic [19:0] pct_factor(input logic [6:0] p);
    return {13'd0, p} * SCALE_RECIP;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rfrc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Opcode and fade target color, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] target_red;
  logic [7:0] target_green;
  logic [7:0] target_blue;

  modport source (output valid, opcode, target_red, target_green, target_blue,
                  input ready);
  modport sink (input valid, opcode, target_red, target_green, target_blue,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/rfrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// PWM duties, power flag and mode, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_red;
  logic [7:0] duty_green;
  logic [7:0] duty_blue;
  logic       power_on;
  logic [1:0] mode;

  modport source (output valid, duty_red, duty_green, duty_blue, power_on, mode,
                  input ready);
  modport sink (input valid, duty_red, duty_green, duty_blue, power_on, mode,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/rfrc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [9:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rfrc_lane.sv =====
// ----------------------------------------------------------------------------
// Color lane
// Per-channel color state, one scaling multiplier, fade step and duty hold.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_lane import rfrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  logic [7:0] target,
  output logic [7:0] duty_next
);

  logic [7:0] ramp_color;
  logic [7:0] start_color;
  logic       delta_neg;
  logic [7:0] delta_mag;
  logic [7:0] stored_color;
  logic [7:0] fade_target;
  logic [7:0] scaled_stored;
  logic [7:0] duty_hold;

  logic [7:0]  mul_a;
  logic [19:0] mul_b;
  logic [27:0] prod;
  logic [27:0] scl_sum;
  logic [8:0]  scl_quo;
  logic [7:0]  scl;
  logic [15:0] div_sum;
  logic [8:0]  new_delta;
  logic        new_neg;
  logic [7:0]  new_mag;
  logic        sel_neg;
  logic [7:0]  sel_start;
  logic [7:0]  sel_q;
  logic [9:0]  fade_sum;
  logic [7:0]  fade_val;

  always_comb begin
    case (ctrl.op)
      LN_RAMP_START: begin
        mul_a = scaled_stored;
        mul_b = ctrl.factor;
      end
      LN_RAMP: begin
        mul_a = ramp_color;
        mul_b = ctrl.factor;
      end
      LN_FADE_START: begin
        mul_a = target;
        mul_b = ctrl.bright_factor;
      end
      LN_FADE_STEP: begin
        mul_a = delta_mag;
        mul_b = {12'd0, ctrl.pct};
      end
      LN_FADE_END: begin
        mul_a = fade_target;
        mul_b = ctrl.bright_factor;
      end
      LN_REFRESH: begin
        mul_a = stored_color;
        mul_b = ctrl.bright_factor;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = {20'd0, mul_a} * {8'd0, mul_b};
  assign scl_sum = prod + SCALE_BIAS;
  assign scl_quo = scl_sum[SCALE_SHIFT +: 9];
  assign scl     = scl_quo[8] ? 8'hFF : scl_quo[7:0];

  // floor(y / 255) for y up to 255 * 255
  assign div_sum = prod[15:0] + 16'd1 + {8'd0, prod[15:8]};

  assign new_delta = {1'b0, scaled_stored} - {1'b0, scl};
  assign new_neg   = new_delta[8];
  assign new_mag   = new_neg ? 8'(-new_delta) : new_delta[7:0];

  always_comb begin
    if (ctrl.op == LN_FADE_START) begin
      sel_neg   = new_neg;
      sel_start = scaled_stored;
      sel_q     = {7'd0, &new_mag};
    end else begin
      sel_neg   = delta_neg;
      sel_start = start_color;
      sel_q     = div_sum[15:8];
    end
    fade_sum = sel_neg ? {2'b00, sel_start} + {2'b00, sel_q}
                       : {2'b00, sel_start} - {2'b00, sel_q};
    if (fade_sum[9]) begin
      fade_val = 8'd0;
    end else if (fade_sum[8]) begin
      fade_val = 8'hFF;
    end else begin
      fade_val = fade_sum[7:0];
    end
  end

  always_comb begin
    case (ctrl.op)
      LN_RAMP_START, LN_RAMP, LN_FADE_END: duty_next = scl;
      LN_BLANK:                            duty_next = 8'd0;
      LN_FADE_START, LN_FADE_STEP:         duty_next = fade_val;
      default:                             duty_next = duty_hold;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_color    <= '0;
      start_color   <= '0;
      delta_neg     <= 1'b0;
      delta_mag     <= '0;
      stored_color  <= '0;
      fade_target   <= '0;
      scaled_stored <= '0;
      duty_hold     <= '0;
    end else begin
      duty_hold <= duty_next;
      case (ctrl.op)
        LN_RAMP_START: ramp_color <= scaled_stored;
        LN_FADE_START: begin
          fade_target <= target;
          start_color <= scaled_stored;
          delta_neg   <= new_neg;
          delta_mag   <= new_mag;
        end
        LN_FADE_END: begin
          stored_color  <= fade_target;
          scaled_stored <= scl;
        end
        LN_REFRESH: scaled_stored <= scl;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfrc_seq.sv =====
// ----------------------------------------------------------------------------
// Ramp sequencer
// Mode, step percent, tick divider and configuration; drives the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_seq import rfrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] opcode,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  output lane_ctrl_t ctrl,
  output logic       power_next,
  output logic [1:0] mode_code,
  output logic       refresh
);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_ON   = 4'b0010,
    MD_OFF  = 4'b0100,
    MD_FADE = 4'b1000
  } mode_t;

  mode_t       mode, mode_next, eff_mode;
  logic        power;
  logic [7:0]  step_pct, pct_next, eff_pct, pct_down;
  logic [19:0] step_factor, factor_next, eff_factor;
  logic [9:0]  tick_count, tick_next, tick_inc;
  logic [19:0] bright_factor;
  logic [9:0]  interval;
  logic        do_step;
  logic        start;

  assign tick_inc = (tick_count != '1) ? tick_count + 10'd1 : tick_count;
  assign pct_down = (eff_pct != 8'd0) ? eff_pct - 8'd1 : 8'd0;

  always_comb begin
    mode_next          = mode;
    power_next         = power;
    pct_next           = step_pct;
    factor_next        = step_factor;
    tick_next          = tick_count;
    do_step            = 1'b0;
    start              = 1'b0;
    eff_mode           = mode;
    eff_pct            = step_pct;
    eff_factor         = step_factor;
    ctrl.op            = refresh ? LN_REFRESH : LN_HOLD;
    ctrl.factor        = step_factor;
    ctrl.pct           = step_pct;
    ctrl.bright_factor = bright_factor;

    if (accept) begin
      case (opcode)
        OP_TICK: begin
          if (mode != MD_IDLE) begin
            if (tick_inc >= interval) begin
              tick_next = '0;
              do_step   = 1'b1;
            end else begin
              tick_next = tick_inc;
            end
          end
        end
        OP_ON: begin
          tick_next  = '0;
          do_step    = 1'b1;
          start      = 1'b1;
          eff_mode   = MD_ON;
          eff_pct    = 8'd1;
          eff_factor = SCALE_RECIP;
        end
        OP_OFF: begin
          tick_next  = '0;
          do_step    = 1'b1;
          start      = 1'b1;
          eff_mode   = MD_OFF;
          eff_pct    = 8'd100;
          eff_factor = FULL_FACTOR;
        end
        OP_FADE: begin
          tick_next = '0;
          do_step   = 1'b1;
          start     = 1'b1;
          eff_mode  = MD_FADE;
          eff_pct   = 8'd1;
        end
        default: ;
      endcase
    end

    if (do_step) begin
      ctrl.pct    = eff_pct;
      ctrl.factor = eff_factor;
      case (eff_mode)
        MD_ON: begin
          ctrl.op   = start ? LN_RAMP_START : LN_RAMP;
          mode_next = MD_ON;
          pct_next  = eff_pct;
          factor_next = eff_factor;
          if (eff_pct >= 8'd100) begin
            mode_next  = MD_IDLE;
            power_next = 1'b1;
          end else begin
            pct_next    = eff_pct + 8'd1;
            factor_next = eff_factor + SCALE_RECIP;
          end
        end
        MD_OFF: begin
          pct_next    = pct_down;
          factor_next = (eff_pct != 8'd0) ? eff_factor - SCALE_RECIP : eff_factor;
          if (pct_down == 8'd0) begin
            ctrl.op    = LN_BLANK;
            mode_next  = MD_IDLE;
            power_next = 1'b0;
          end else begin
            ctrl.op   = start ? LN_RAMP_START : LN_RAMP;
            mode_next = MD_OFF;
          end
        end
        MD_FADE: begin
          if (eff_pct != 8'hFF) begin
            ctrl.op   = start ? LN_FADE_START : LN_FADE_STEP;
            mode_next = MD_FADE;
            pct_next  = eff_pct + 8'd1;
          end else begin
            ctrl.op   = LN_FADE_END;
            mode_next = MD_IDLE;
            pct_next  = eff_pct;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_next)
      MD_ON:   mode_code = MODE_ON;
      MD_OFF:  mode_code = MODE_OFF;
      MD_FADE: mode_code = MODE_FADE;
      default: mode_code = MODE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MD_IDLE;
      power         <= 1'b0;
      step_pct      <= 8'd1;
      step_factor   <= SCALE_RECIP;
      tick_count    <= '0;
      bright_factor <= pct_factor(BRIGHT_RESET);
      interval      <= INTERVAL_RESET;
      refresh       <= 1'b0;
    end else begin
      mode        <= mode_next;
      power       <= power_next;
      step_pct    <= pct_next;
      step_factor <= factor_next;
      tick_count  <= tick_next;
      refresh     <= cfg_write && (cfg_index == REG_BRIGHTNESS);
      if (cfg_write) begin
        case (cfg_index)
          REG_BRIGHTNESS: bright_factor <= pct_factor(cfg_data[6:0]);
          REG_INTERVAL:   interval      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rfrc_merge.sv =====
// ----------------------------------------------------------------------------
// Result merge stage
// Joins lane duties with power and mode into an output register with skid.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_merge import rfrc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t data,
  output logic    space,
  rfrc_rsp_if.source rsp
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      out_data <= skid_valid ? skid_data : data;
    end else if (push) begin
      skid_data <= data;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.duty_red   = out_data.duty_red;
  assign rsp.duty_green = out_data.duty_green;
  assign rsp.duty_blue  = out_data.duty_blue;
  assign rsp.power_on   = out_data.power_on;
  assign rsp.mode       = out_data.mode;

endmodule

`default_nettype wire

// ===== rtl/rgb_fade_and_ramp_controller_core.sv =====
// ----------------------------------------------------------------------------
// RGB fade and ramp controller core
// Three color lanes under one ramp sequencer, results through a skid stage.
//
//   Port  Dir   Moves
//   req   sink  opcode, target_red/green/blue
//   rsp   src   duty_red/green/blue, power_on, mode
//   cfg   sink  index, data (0 brightness_percent, 1 step_interval)
//
// One request per cycle while req.ready is high; results leave through a register.
// Each lane path is one 8x20 scaling multiply plus a fixed /255 fold.
// A brightness write blocks req in the next cycle while the lanes rescale.
// rsp stall: one request still accepted into the skid slot, then req.ready drops.
// Synchronous reset restores brightness 100, interval 3, lamp dark and idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_fade_and_ramp_controller_core import rfrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  rfrc_req_if.sink   req,
  rfrc_rsp_if.source rsp,
  rfrc_cfg_if.sink   cfg
);

  lane_ctrl_t ctrl;
  logic       accept;
  logic       space;
  logic       refresh;
  logic       power_next;
  logic [1:0] mode_code;
  logic [7:0] target [3];
  logic [7:0] duty   [3];
  result_t    result;

  assign req.ready = space && !refresh;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign target[0] = req.target_red;
  assign target[1] = req.target_green;
  assign target[2] = req.target_blue;

  rfrc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (req.opcode),
    .cfg_write  (cfg.valid && cfg.ready),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .ctrl       (ctrl),
    .power_next (power_next),
    .mode_code  (mode_code),
    .refresh    (refresh)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    rfrc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .target    (target[c]),
      .duty_next (duty[c])
    );
  end

  assign result.duty_red   = duty[0];
  assign result.duty_green = duty[1];
  assign result.duty_blue  = duty[2];
  assign result.power_on   = power_next;
  assign result.mode       = mode_code;

  rfrc_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .data  (result),
    .space (space),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/rfrc_checker.sv =====
// ----------------------------------------------------------------------------
// RGB fade and ramp controller checker
// Port-level checks on result timing, fade mode and brightness rescale.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_fade_and_ramp_controller_core_assert.svh"

module rfrc_checker import rfrc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic [1:0] req_opcode,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] rsp_mode,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic       cfg_index
);

  `RFRC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp_valid, "result valid after reset")
  `RFRC_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")
  `RFRC_ASSERT(a_req_result, clk, rst, req_valid && req_ready |=> rsp_valid, "request lost")
  `RFRC_ASSERT(a_fade_mode, clk, rst, req_valid && req_ready && req_opcode == OP_FADE && (!rsp_valid || rsp_ready) |=> rsp_mode == MODE_FADE, "fade not reported")
  `RFRC_ASSERT(a_rescale_block, clk, rst, cfg_valid && cfg_ready && cfg_index == REG_BRIGHTNESS |=> !req_ready, "request taken during rescale")

endmodule

bind rgb_fade_and_ramp_controller_core rfrc_checker u_rfrc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_opcode (req.opcode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_mode   (rsp.mode),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .cfg_index  (cfg.index)
);

`default_nettype wire

// ===== tb/sv/tb_rgb_fade_and_ramp_controller_core.sv =====
// ----------------------------------------------------------------------------
// RGB fade and ramp controller testbench
// Drives tick, turn-on, turn-off and fade requests with random gaps and
// result stalls. A scoreboard tracks the lamp's ramp and fade state and checks
// every result field against its prediction. Brightness and step interval
// are rewritten between phases, including zero, above one hundred and the
// widest interval.
// ----------------------------------------------------------------------------
module tb_rgb_fade_and_ramp_controller_core;
  import rfrc_pkg::*;

  localparam int unsigned FULL_PERCENT = 100;
  localparam int unsigned FADE_STEPS = 255;
  localparam int unsigned MAX_TICKS = 1023;
  localparam int TOTAL_REQUESTS = 1550;

  class duty_scoreboard;
    logic [6:0] bright;
    logic [9:0] interval;
    logic [1:0] ramp_mode;
    logic       power;
    logic [7:0] step_pct;
    logic [9:0] ticks;
    logic [7:0] ramp_c [3];
    logic [7:0] start_c [3];
    logic [7:0] stored_c [3];
    logic [7:0] target_c [3];
    logic [7:0] duty [3];
    int         delta [3];
    result_t    expected_duties [$];
    int         errors;

    function new();
      bright = BRIGHT_RESET;
      interval = INTERVAL_RESET;
      ramp_mode = MODE_IDLE;
      power = 1'b0;
      step_pct = 8'd1;
      ticks = '0;
      errors = 0;
      for (int c = 0; c < 3; c++) begin
        ramp_c[c] = '0;
        start_c[c] = '0;
        stored_c[c] = '0;
        target_c[c] = '0;
        duty[c] = '0;
        delta[c] = 0;
      end
    endfunction

    function automatic logic [7:0] scale_by_percent(int unsigned v, int unsigned p);
      int unsigned r;
      r = (v * p + 50) / FULL_PERCENT;
      return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function void set_register(logic idx, logic [9:0] data);
      if (idx == REG_BRIGHTNESS) bright = data[6:0];
      else interval = data;
    endfunction

    function void advance_ramp();
      int          d;
      int          v;
      int unsigned mag;
      int unsigned q;
      case (ramp_mode)
        MODE_ON: begin
          for (int c = 0; c < 3; c++) duty[c] = scale_by_percent(ramp_c[c], step_pct);
          if (step_pct >= FULL_PERCENT) begin
            ramp_mode = MODE_IDLE;
            power = 1'b1;
          end else begin
            step_pct++;
          end
        end
        MODE_OFF: begin
          for (int c = 0; c < 3; c++) duty[c] = scale_by_percent(ramp_c[c], step_pct);
          if (step_pct > 0) step_pct--;
          if (step_pct == 0) begin
            ramp_mode = MODE_IDLE;
            power = 1'b0;
            for (int c = 0; c < 3; c++) duty[c] = '0;
          end
        end
        MODE_FADE: begin
          for (int c = 0; c < 3; c++) begin
            d = delta[c];
            mag = (d < 0) ? -d : d;
            q = (step_pct * mag) / FADE_STEPS;
            v = int'(start_c[c]) - ((d < 0) ? -int'(q) : int'(q));
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            duty[c] = v[7:0];
          end
          if (step_pct < FADE_STEPS) begin
            step_pct++;
          end else begin
            ramp_mode = MODE_IDLE;
            for (int c = 0; c < 3; c++) begin
              stored_c[c] = target_c[c];
              duty[c] = scale_by_percent(stored_c[c], bright);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] tr, logic [7:0] tg,
                               logic [7:0] tb);
      logic [7:0] tgt [3];
      logic [7:0] tgt_scaled;
      result_t    res;
      tgt[0] = tr;
      tgt[1] = tg;
      tgt[2] = tb;
      if (op == OP_TICK) begin
        if (ramp_mode != MODE_IDLE) begin
          if (ticks < MAX_TICKS) ticks++;
          if (ticks >= interval) begin
            ticks = '0;
            advance_ramp();
          end
        end
      end else begin
        ticks = '0;
        if (op == OP_ON || op == OP_OFF) begin
          for (int c = 0; c < 3; c++) ramp_c[c] = scale_by_percent(stored_c[c], bright);
          ramp_mode = (op == OP_ON) ? MODE_ON : MODE_OFF;
          step_pct = (op == OP_ON) ? 8'd1 : 8'(FULL_PERCENT);
        end else begin
          for (int c = 0; c < 3; c++) begin
            tgt_scaled = scale_by_percent(tgt[c], bright);
            target_c[c] = tgt[c];
            start_c[c] = scale_by_percent(stored_c[c], bright);
            delta[c] = int'(start_c[c]) - int'(tgt_scaled);
          end
          ramp_mode = MODE_FADE;
          step_pct = 8'd1;
        end
        advance_ramp();
      end
      res.duty_red = duty[0];
      res.duty_green = duty[1];
      res.duty_blue = duty[2];
      res.power_on = power;
      res.mode = ramp_mode;
      expected_duties.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_duties.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, got);
        return;
      end
      want = expected_duties.pop_front();
      compare_field("duty_red", want.duty_red, got.duty_red);
      compare_field("duty_green", want.duty_green, got.duty_green);
      compare_field("duty_blue", want.duty_blue, got.duty_blue);
      compare_field("power_on", want.power_on, got.power_on);
      compare_field("mode", want.mode, got.mode);
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  rfrc_req_if req ();
  rfrc_rsp_if rsp ();
  rfrc_cfg_if cfg ();

  rgb_fade_and_ramp_controller_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  duty_scoreboard duty_board = new();
  bit             no_gaps;
  int             sent;

  always #1 clk = ~clk;

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] pick_color();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_request(logic [1:0] op, logic [7:0] tr, logic [7:0] tg,
                              logic [7:0] tb);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.target_red <= tr;
    req.target_green <= tg;
    req.target_blue <= tb;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    duty_board.note_request(op, tr, tg, tb);
    sent++;
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (duty_board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [9:0] bright, logic [9:0] interval);
    cfg.valid <= 1'b1;
    cfg.index <= REG_BRIGHTNESS;
    cfg.data <= bright;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    duty_board.set_register(REG_BRIGHTNESS, bright);
    cfg.index <= REG_INTERVAL;
    cfg.data <= interval;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    duty_board.set_register(REG_INTERVAL, interval);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [9:0] pick_brightness();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd100;
      3: return 10'd127;
      4: return 10'($urandom_range(0, 1023));
      default: return 10'($urandom_range(1, 100));
    endcase
  endfunction

  function automatic logic [9:0] pick_interval();
    case ($urandom_range(0, 9))
      4: return 10'd0;
      5: return 10'd2;
      6: return 10'd3;
      7: return 10'($urandom_range(4, 20));
      8: return 10'd1023;
      9: return 10'($urandom_range(0, 1023));
      default: return 10'd1;
    endcase
  endfunction

  task automatic run_sequence();
    logic [1:0]  op;
    int unsigned steps;
    int unsigned eff;
    int          n;
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 20))
        send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      op = 2'($urandom_range(1, 3));
      send_request(op, pick_color(), pick_color(), pick_color());
      steps = (op == OP_FADE) ? FADE_STEPS : FULL_PERCENT;
      eff = (duty_board.interval == 0) ? 1 : duty_board.interval;
      if (eff <= 2 && $urandom_range(0, 2) != 0) n = steps * eff + $urandom_range(0, 8);
      else n = $urandom_range(0, (eff * 4 > 60) ? 60 : eff * 4);
      repeat (n) send_request(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      duty_board.check_result('{duty_red: rsp.duty_red, duty_green: rsp.duty_green,
                                duty_blue: rsp.duty_blue, power_on: rsp.power_on,
                                mode: rsp.mode});
    end
  end

  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.opcode <= OP_TICK;
    req.target_red <= '0;
    req.target_green <= '0;
    req.target_blue <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_BRIGHTNESS;
    cfg.data <= '0;
    no_gaps = 1'b0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_TICK, 8'd255, 8'd255, 8'd255);
    send_request(OP_ON, 8'd255, 8'd0, 8'd170);
    repeat (3) send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_OFF, 8'd85, 8'd255, 8'd0);
    repeat (3) send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_FADE, 8'd255, 8'd0, 8'd128);
    repeat (4) send_request(OP_TICK, 8'd0, 8'd0, 8'd0);
    send_request(OP_FADE, 8'd0, 8'd255, 8'd1);
    send_request(OP_ON, 8'd0, 8'd0, 8'd0);
    send_request(OP_OFF, 8'd255, 8'd255, 8'd255);
    repeat (3) send_request(OP_TICK, 8'd255, 8'd255, 8'd255);
    drain_results();
    write_config(10'd127, 10'd0);
    send_request(OP_FADE, 8'd255, 8'd255, 8'd255);
    send_request(OP_TICK, 8'd0, 8'd0, 8'd0);

    while (sent < TOTAL_REQUESTS) begin
      drain_results();
      write_config(pick_brightness(), pick_interval());
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (sent < TOTAL_REQUESTS) run_sequence();
      end
    end

    no_gaps = 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    if (duty_board.errors == 0 && duty_board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
